>>> rtl/core/colormap_gradient_pixel_defines.svh
// ----------------------------------------------------------------------------
// colormap_gradient_pixel_defines.svh
// Assertion macros shared by the colormap pixel RTL.
// ----------------------------------------------------------------------------
`ifndef COLORMAP_GRADIENT_PIXEL_DEFINES_SVH
`define COLORMAP_GRADIENT_PIXEL_DEFINES_SVH

// Condition must hold on every edge outside reset.
`define CGP_ASSERT_HOLD(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// Condition in one cycle forces the consequence in the next.
`define CGP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Condition must hold on the edge after any reset cycle.
`define CGP_ASSERT_AFTER_RESET(label, cond, msg) \
   label: assert property (@(posedge clock) (reset) |=> (cond)) \
      else $error(msg);

`endif

>>> rtl/core/cgp_pkg.sv
// ----------------------------------------------------------------------------
// cgp_pkg
// Types, constants and gradient tables of the colormap pixel block.
// ----------------------------------------------------------------------------
package cgp_pkg;

   localparam int SAMPLE_W                 = 32;
   localparam int SAMPLE_FRAC_BITS_DEFAULT = 16;
   localparam int NORM_FRAC_BITS           = 16;
   localparam int FRAC_W                   = NORM_FRAC_BITS + 1;
   localparam int COLOR_W                  = 8;
   localparam int SEL_W                    = 3;
   localparam int CSR_INDEX_W              = 2;
   localparam int STOP_COUNT               = 17;
   localparam int STOP_IDX_W               = $clog2(STOP_COUNT);
   localparam int SEG_W                    = 3;

   localparam logic [FRAC_W-1:0] NORM_ONE = FRAC_W'(1) << NORM_FRAC_BITS;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MIN_VALUE       = 2'd0,
      CSR_INV_RANGE_SCALE = 2'd1,
      CSR_COLORMAP_SELECT = 2'd2
   } csr_index_type;

   typedef enum logic [SEL_W-1:0] {
      MAP_JET       = 3'd0,
      MAP_HOT       = 3'd1,
      MAP_GRAYSCALE = 3'd2,
      MAP_VIRIDIS   = 3'd3
   } map_select_type;

   // Gradient stops as 0xRRGGBB: jet at 0, hot at 7, grayscale at 11, viridis at 13.
   localparam logic [3*COLOR_W-1:0] STOP_COLORS [STOP_COUNT] = '{
      24'h000080, 24'h0000FF, 24'h00FFFF, 24'h00FF00, 24'hFFFF00, 24'hFF0000, 24'h800000,
      24'h000000, 24'hFF0000, 24'hFFFF00, 24'hFFFFFF,
      24'h000000, 24'hFFFFFF,
      24'h440154, 24'h31688E, 24'h35B779, 24'hFDE724
   };

   function automatic logic [STOP_IDX_W-1:0] map_offset(input logic [SEL_W-1:0] sel);
      logic [STOP_IDX_W-1:0] off;
      unique case (map_select_type'(sel))
         MAP_JET:     off = STOP_IDX_W'(0);
         MAP_HOT:     off = STOP_IDX_W'(7);
         MAP_VIRIDIS: off = STOP_IDX_W'(13);
         default:     off = STOP_IDX_W'(11);
      endcase
      return off;
   endfunction

   // Number of segments (stops - 1).
   function automatic logic [SEG_W-1:0] map_segments(input logic [SEL_W-1:0] sel);
      logic [SEG_W-1:0] segs;
      unique case (map_select_type'(sel))
         MAP_JET:     segs = SEG_W'(6);
         MAP_HOT:     segs = SEG_W'(3);
         MAP_VIRIDIS: segs = SEG_W'(3);
         default:     segs = SEG_W'(1);
      endcase
      return segs;
   endfunction

endpackage

>>> rtl/core/colormap_gradient_pixel.sv
// Stages: stage 1 offset, stage 2 32x32 multiply, stage 3 normalize and stop lookup,
//   stage 4 interpolation into the response register.
// Throughput: one request per clock while rsp_ready does not stall the output;
//   the 32x32 scale multiply is the deepest path.
// Reset: synchronous, clears all valid bits and loads min_value 0,
//   inv_range_scale 2^(32-SAMPLE_FRAC_BITS), colormap_select 0.
// ----------------------------------------------------------------------------
// colormap_gradient_pixel
// False-color mapping of one Q16.16 sample onto a piecewise-linear gradient.
// ----------------------------------------------------------------------------
`include "colormap_gradient_pixel_defines.svh"

module colormap_gradient_pixel #(
   parameter int SAMPLE_FRAC_BITS = cgp_pkg::SAMPLE_FRAC_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [cgp_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                req_sample_invalid,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [cgp_pkg::COLOR_W-1:0]         rsp_red,
   output logic [cgp_pkg::COLOR_W-1:0]         rsp_green,
   output logic [cgp_pkg::COLOR_W-1:0]         rsp_blue,
   // register write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [cgp_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [cgp_pkg::SAMPLE_W-1:0]        csr_wdata
);

   localparam int W       = cgp_pkg::SAMPLE_W;
   localparam int CW      = cgp_pkg::COLOR_W;
   localparam int FW      = cgp_pkg::FRAC_W;
   localparam int NF      = cgp_pkg::NORM_FRAC_BITS;
   localparam int PROD_W  = 2 * W;
   localparam int POS_W   = FW + cgp_pkg::SEG_W;
   localparam logic [W-1:0] SCALE_RESET = W'(1) << (W - SAMPLE_FRAC_BITS);

   // ---------------------------------------------------------------------
   // Configuration registers; software must write them only while idle, unchecked by the block.
   // ---------------------------------------------------------------------
   logic signed [W-1:0]             min_value_ff, min_value_in;
   logic [W-1:0]                    scale_ff, scale_in;
   logic [cgp_pkg::SEL_W-1:0]       select_ff, select_in;

   assign csr_ready = 1'b1;

   always_comb begin
      min_value_in = min_value_ff;
      scale_in     = scale_ff;
      select_in    = select_ff;
      if (csr_valid) begin
         unique case (cgp_pkg::csr_index_type'(csr_index))
            cgp_pkg::CSR_MIN_VALUE:       min_value_in = $signed(csr_wdata);
            cgp_pkg::CSR_INV_RANGE_SCALE: scale_in     = csr_wdata;
            cgp_pkg::CSR_COLORMAP_SELECT: select_in    = csr_wdata[cgp_pkg::SEL_W-1:0];
            default: ;  // drop writes past the register list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_value_ff <= '0;
         scale_ff     <= SCALE_RESET;
         select_ff    <= '0;
      end else begin
         min_value_ff <= min_value_in;
         scale_ff     <= scale_in;
         select_ff    <= select_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage advance: a stage loads when it is empty or its successor moves.
   // ---------------------------------------------------------------------
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, rsp_valid_ff;
   logic s1_adv, s2_adv, s3_adv, out_adv;

   assign out_adv   = !rsp_valid_ff || rsp_ready;
   assign s3_adv    = !s3_valid_ff || out_adv;
   assign s2_adv    = !s2_valid_ff || s3_adv;
   assign s1_adv    = !s1_valid_ff || s2_adv;
   assign req_ready = s1_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_adv)  s1_valid_ff  <= req_valid;
         if (s2_adv)  s2_valid_ff  <= s1_valid_ff;
         if (s3_adv)  s3_valid_ff  <= s2_valid_ff;
         if (out_adv) rsp_valid_ff <= s3_valid_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: offset by the minimum, exact in W+1 bits. Only a positive
   // difference goes on; anything at or below the minimum maps to zero.
   // ---------------------------------------------------------------------
   logic signed [W:0] s1_diff;
   logic [W-1:0]      s1_dist_ff;
   logic              s1_pos_ff, s1_inv_ff;

   assign s1_diff = {req_sample[W-1], req_sample} - {min_value_ff[W-1], min_value_ff};

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s1_dist_ff <= s1_diff[W-1:0];
         s1_pos_ff  <= !s1_diff[W] && (s1_diff != '0);
         s1_inv_ff  <= req_sample_invalid;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: scale multiply, registered before anything else touches it.
   // ---------------------------------------------------------------------
   logic [PROD_W-1:0] s2_prod_ff;
   logic              s2_pos_ff, s2_inv_ff;

   always_ff @(posedge clock) begin
      if (s2_adv) begin
         s2_prod_ff <= PROD_W'(s1_dist_ff) * PROD_W'(scale_ff);
         s2_pos_ff  <= s1_pos_ff;
         s2_inv_ff  <= s1_inv_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: saturate to 1.0, place on the gradient, fetch both stops.
   // ---------------------------------------------------------------------
   logic                            s3_sat;
   logic [FW-1:0]                   s3_norm;
   logic [cgp_pkg::SEG_W-1:0]       s3_segs, s3_last, s3_idx_raw, s3_idx;
   logic [POS_W-1:0]                s3_pos;
   logic [cgp_pkg::STOP_IDX_W-1:0]  s3_base;
   logic [3*CW-1:0]                 s3_c1_ff, s3_c2_ff;
   logic [FW-1:0]                   s3_frac_ff;
   logic                            s3_inv_ff;

   always_comb begin
      s3_sat     = s2_prod_ff[PROD_W-1:NF] > (PROD_W-NF)'(cgp_pkg::NORM_ONE);
      if (!s2_pos_ff)  s3_norm = '0;
      else if (s3_sat) s3_norm = cgp_pkg::NORM_ONE;
      else             s3_norm = s2_prod_ff[NF +: FW];
      s3_segs    = cgp_pkg::map_segments(select_ff);
      s3_last    = s3_segs - cgp_pkg::SEG_W'(1);
      s3_pos     = POS_W'(s3_norm) * POS_W'(s3_segs);
      s3_idx_raw = s3_pos[NF +: cgp_pkg::SEG_W];
      // clamp so the top of the range stays on the last segment with frac 1.0
      s3_idx     = (s3_idx_raw > s3_last) ? s3_last : s3_idx_raw;
      s3_base    = cgp_pkg::map_offset(select_ff) + cgp_pkg::STOP_IDX_W'(s3_idx);
   end

   always_ff @(posedge clock) begin
      if (s3_adv) begin
         s3_c1_ff   <= cgp_pkg::STOP_COLORS[s3_base];
         s3_c2_ff   <= cgp_pkg::STOP_COLORS[s3_base + cgp_pkg::STOP_IDX_W'(1)];
         s3_frac_ff <= FW'(s3_pos - (POS_W'(s3_idx) << NF));
         s3_inv_ff  <= s2_inv_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 4: per-channel interpolation into the response register.
   // ---------------------------------------------------------------------
   logic [CW-1:0] lerp_red, lerp_green, lerp_blue;
   logic [CW-1:0] rsp_red_ff, rsp_green_ff, rsp_blue_ff;

   cgp_lerp u_lerp_red (
      .c_start (s3_c1_ff[2*CW +: CW]),
      .c_end   (s3_c2_ff[2*CW +: CW]),
      .frac    (s3_frac_ff),
      .level   (lerp_red)
   );

   cgp_lerp u_lerp_green (
      .c_start (s3_c1_ff[CW +: CW]),
      .c_end   (s3_c2_ff[CW +: CW]),
      .frac    (s3_frac_ff),
      .level   (lerp_green)
   );

   cgp_lerp u_lerp_blue (
      .c_start (s3_c1_ff[0 +: CW]),
      .c_end   (s3_c2_ff[0 +: CW]),
      .frac    (s3_frac_ff),
      .level   (lerp_blue)
   );

   // Invalid samples (NaN or Inf at the source) give black.
   always_ff @(posedge clock) begin
      if (out_adv) begin
         rsp_red_ff   <= s3_inv_ff ? '0 : lerp_red;
         rsp_green_ff <= s3_inv_ff ? '0 : lerp_green;
         rsp_blue_ff  <= s3_inv_ff ? '0 : lerp_blue;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_red   = rsp_red_ff;
   assign rsp_green = rsp_green_ff;
   assign rsp_blue  = rsp_blue_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   `CGP_ASSERT_AFTER_RESET(a_reset_empty, !rsp_valid_ff && !s1_valid_ff, "pipeline not empty after reset")
   `CGP_ASSERT_HOLD(a_frac_range, !s3_valid_ff || (s3_frac_ff <= cgp_pkg::NORM_ONE), "interpolation fraction above 1.0")
   `CGP_ASSERT_NEXT(a_invalid_black, s3_valid_ff && s3_inv_ff && out_adv, rsp_red == '0 && rsp_green == '0 && rsp_blue == '0, "invalid sample not black")
   `CGP_ASSERT_NEXT(a_stage3_hold, s3_valid_ff && !out_adv, s3_valid_ff && $stable(s3_frac_ff) && $stable(s3_c1_ff), "stage 3 lost data under stall")

endmodule

>>> rtl/core/cgp_lerp.sv
// ----------------------------------------------------------------------------
// cgp_lerp
// One color channel: c_start + frac * (c_end - c_start), truncated.
// ----------------------------------------------------------------------------
module cgp_lerp (
   input  logic [cgp_pkg::COLOR_W-1:0] c_start,
   input  logic [cgp_pkg::COLOR_W-1:0] c_end,
   input  logic [cgp_pkg::FRAC_W-1:0]  frac,
   output logic [cgp_pkg::COLOR_W-1:0] level
);

   localparam int ACC_W = cgp_pkg::FRAC_W + cgp_pkg::COLOR_W + 2;

   logic signed [cgp_pkg::COLOR_W:0] diff;
   logic signed [ACC_W-1:0]          acc;

   // Result always lies between the two stops, so acc never goes negative.
   assign diff  = $signed({1'b0, c_end}) - $signed({1'b0, c_start});
   assign acc   = $signed({{(ACC_W-cgp_pkg::COLOR_W-cgp_pkg::NORM_FRAC_BITS){1'b0}},
                           c_start, {cgp_pkg::NORM_FRAC_BITS{1'b0}}})
                + $signed({1'b0, frac}) * diff;
   assign level = acc[cgp_pkg::NORM_FRAC_BITS +: cgp_pkg::COLOR_W];

endmodule

>>> dv/colormap_gradient_pixel_test.sv
// ----------------------------------------------------------------------------
// colormap_gradient_pixel_test
// Self-checking bench for the colormap pixel block. A scoreboard predicts
// each pixel from the request and the current register settings. It then
// compares the responses in order, field by field. The stimulus is a short
// directed set of corner samples, followed by random phases, each with its
// own minimum, range and gradient. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module colormap_gradient_pixel_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int          HALF_PERIOD     = 6;
   localparam int          RESET_CYCLES    = 8;
   localparam int          RANDOM_PHASES   = 12;
   localparam int          ITEMS_PER_PHASE = 157;
   localparam int          DRAIN_CYCLES    = 20;
   localparam int          CYCLE_LIMIT     = 500_000;
   localparam int          PRESSURE_AT     = 700;
   localparam int          PRESSURE_CYCLES = 150;
   localparam int          MAX_REPORTS     = 40;
   localparam int unsigned NORM_UNITY      = 32'd1 << cgp_pkg::NORM_FRAC_BITS;

   // Register index past the end of the register list; writes to it are dropped.
   localparam logic [cgp_pkg::CSR_INDEX_W-1:0] CSR_UNUSED_INDEX = 2'd3;

   // Selector codes past the named gradients; both fall back to grayscale.
   localparam logic [cgp_pkg::SEL_W-1:0] MAP_SPARE_LOW = 3'd5;
   localparam logic [cgp_pkg::SEL_W-1:0] MAP_SPARE_TOP = 3'd7;

   // Gradient stops as 0xRRGGBB: jet at 0, hot at 7, grayscale at 11, viridis at 13.
   localparam bit [23:0] GRADIENT_STOPS [17] = '{
      24'h000080, 24'h0000FF, 24'h00FFFF, 24'h00FF00, 24'hFFFF00, 24'hFF0000, 24'h800000,
      24'h000000, 24'hFF0000, 24'hFFFF00, 24'hFFFFFF,
      24'h000000, 24'hFFFFFF,
      24'h440154, 24'h31688E, 24'h35B779, 24'hFDE724
   };

   typedef struct packed {
      bit [7:0] red;
      bit [7:0] green;
      bit [7:0] blue;
   } rgb_pixel_type;

   typedef enum int {
      READY_ALWAYS,
      READY_HALF,
      READY_SPARSE,
      READY_ALTERNATE
   } ready_pattern_type;

   // -------------------------------------------------------------------------
   // Scoreboard: holds a copy of the registers and the queue of pixels owed.
   // -------------------------------------------------------------------------
   class pixel_scoreboard;
      rgb_pixel_type    expected_pixels[$];
      int unsigned      mismatch_count;
      int unsigned      accepted_count;
      int unsigned      pixel_count;
      bit signed [31:0] min_value;
      bit [31:0]        inv_range_scale;
      bit [2:0]         colormap_select;

      function new();
         min_value       = '0;
         inv_range_scale = 32'd1 << (32 - cgp_pkg::SAMPLE_FRAC_BITS_DEFAULT);
         colormap_select = cgp_pkg::MAP_JET;
      endfunction

      function void write_register(logic [cgp_pkg::CSR_INDEX_W-1:0] index,
                                   logic [31:0] value);
         case (index)
            cgp_pkg::CSR_MIN_VALUE:       min_value       = value;
            cgp_pkg::CSR_INV_RANGE_SCALE: inv_range_scale = value;
            cgp_pkg::CSR_COLORMAP_SELECT: colormap_select = value[2:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction

      // Linear blend of one channel; the result always lies between the two stops.
      function bit [7:0] blend(bit [7:0] c_lo, bit [7:0] c_hi, int unsigned frac);
         longint acc;
         acc = longint'(c_lo) * NORM_UNITY + longint'(frac) * (longint'(c_hi) - longint'(c_lo));
         return 8'(acc >>> cgp_pkg::NORM_FRAC_BITS);
      endfunction

      function rgb_pixel_type map_sample(bit signed [31:0] sample, bit invalid);
         longint          diff;
         longint unsigned diff_mag;
         longint unsigned norm;
         longint unsigned pos;
         int unsigned     base;
         int unsigned     segs;
         int unsigned     seg;
         int unsigned     frac;
         bit [23:0]       lo;
         bit [23:0]       hi;
         rgb_pixel_type   px;

         if (invalid)
            return '0;

         diff = longint'(sample) - longint'(min_value);
         if (diff <= 0) begin
            norm = 0;
         end else begin
            diff_mag = diff;
            norm = (diff_mag * {32'h0, inv_range_scale}) >> cgp_pkg::NORM_FRAC_BITS;
            if (norm > NORM_UNITY)
               norm = NORM_UNITY;
         end

         case (colormap_select)
            cgp_pkg::MAP_JET:     begin base = 0;  segs = 6; end
            cgp_pkg::MAP_HOT:     begin base = 7;  segs = 3; end
            cgp_pkg::MAP_VIRIDIS: begin base = 13; segs = 3; end
            default:              begin base = 11; segs = 1; end
         endcase

         pos = norm * segs;
         seg = 32'(pos >> cgp_pkg::NORM_FRAC_BITS);
         if (seg > segs - 1)
            seg = segs - 1;
         frac = 32'(pos - ({32'h0, seg} << cgp_pkg::NORM_FRAC_BITS));

         lo = GRADIENT_STOPS[base + seg];
         hi = GRADIENT_STOPS[base + seg + 1];
         px.red   = blend(lo[23:16], hi[23:16], frac);
         px.green = blend(lo[15:8],  hi[15:8],  frac);
         px.blue  = blend(lo[7:0],   hi[7:0],   frac);
         return px;
      endfunction

      function void note_request(bit signed [31:0] sample, bit invalid);
         expected_pixels.push_back(map_sample(sample, invalid));
         accepted_count++;
      endfunction

      task report_mismatch(string what);
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("ERROR pixel %0d at %0t: %s", pixel_count, $realtime, what);
      endtask

      task check_pixel(logic [7:0] red, logic [7:0] green, logic [7:0] blue);
         rgb_pixel_type want;
         if (expected_pixels.size() == 0) begin
            report_mismatch("response with no request outstanding");
            return;
         end
         want = expected_pixels.pop_front();
         if (red !== want.red)
            report_mismatch($sformatf("red %0d, want %0d", red, want.red));
         if (green !== want.green)
            report_mismatch($sformatf("green %0d, want %0d", green, want.green));
         if (blue !== want.blue)
            report_mismatch($sformatf("blue %0d, want %0d", blue, want.blue));
         pixel_count++;
      endtask
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and block ports; every input starts at a known value.
   // -------------------------------------------------------------------------
   logic                                clock              = 1'b0;
   logic                                reset              = 1'b1;
   logic                                req_valid          = 1'b0;
   logic                                req_ready;
   logic signed [cgp_pkg::SAMPLE_W-1:0] req_sample         = '0;
   logic                                req_sample_invalid = 1'b0;
   logic                                rsp_valid;
   logic                                rsp_ready          = 1'b0;
   logic [cgp_pkg::COLOR_W-1:0]         rsp_red;
   logic [cgp_pkg::COLOR_W-1:0]         rsp_green;
   logic [cgp_pkg::COLOR_W-1:0]         rsp_blue;
   logic                                csr_valid          = 1'b0;
   logic                                csr_ready;
   logic [cgp_pkg::CSR_INDEX_W-1:0]     csr_index          = '0;
   logic [cgp_pkg::SAMPLE_W-1:0]        csr_wdata          = '0;

   pixel_scoreboard pixel_board;
   int unsigned     cycle_count;

   always #(HALF_PERIOD) clock = ~clock;

   colormap_gradient_pixel u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_sample         (req_sample),
      .req_sample_invalid (req_sample_invalid),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_red            (rsp_red),
      .rsp_green          (rsp_green),
      .rsp_blue           (rsp_blue),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   // -------------------------------------------------------------------------
   // Watchdog: end the run if the block hangs.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL colormap_gradient_pixel");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Response side: check every accepted pixel at the rising edge.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         pixel_board.check_pixel(rsp_red, rsp_green, rsp_blue);
   end

   // Drive rsp_ready at the falling edge. Switch between a few stall patterns,
   // and once, well into the run, hold off for a long stretch so that the
   // pipeline fills and pushes back on the request side.
   ready_pattern_type ready_pattern = READY_ALWAYS;
   int unsigned       pattern_left;
   int unsigned       hold_left;
   bit                pressure_done;

   always @(negedge clock) begin
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (!pressure_done && pixel_board != null &&
                   pixel_board.accepted_count >= PRESSURE_AT) begin
         pressure_done = 1'b1;
         hold_left     = PRESSURE_CYCLES - 1;
         rsp_ready    <= 1'b0;
      end else begin
         if (pattern_left == 0) begin
            ready_pattern = ready_pattern_type'($urandom_range(0, 3));
            pattern_left  = $urandom_range(8, 64);
         end else begin
            pattern_left--;
         end
         case (ready_pattern)
            READY_ALWAYS:    rsp_ready <= 1'b1;
            READY_HALF:      rsp_ready <= 1'($urandom_range(0, 1));
            READY_SPARSE:    rsp_ready <= ($urandom_range(0, 4) == 0);
            READY_ALTERNATE: rsp_ready <= ~rsp_ready;
            default:         rsp_ready <= 1'b1;
         endcase
      end
   end

   // -------------------------------------------------------------------------
   // Request side tasks. Change inputs at the falling edge and look for the
   // handshake at the rising edge.
   // -------------------------------------------------------------------------

   // Offer one request and hold it until accepted; valid stays high afterwards
   // so that back-to-back requests need no extra assignment.
   task automatic send_request(input logic signed [cgp_pkg::SAMPLE_W-1:0] sample,
                               input logic invalid);
      @(negedge clock);
      req_valid          <= 1'b1;
      req_sample         <= sample;
      req_sample_invalid <= invalid;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      pixel_board.note_request(sample, invalid);
   endtask

   // Drop valid for a gap of the given number of cycles.
   task automatic idle_request(input int unsigned cycles);
      if (cycles != 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (cycles - 1)
            @(negedge clock);
      end
   endtask

   // Drop valid and wait until every owed pixel has come back.
   task automatic drain_pixels();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pixel_board.pending() != 0)
         @(posedge clock);
   endtask

   task automatic write_csr(input logic [cgp_pkg::CSR_INDEX_W-1:0] index,
                            input logic [31:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      pixel_board.write_register(index, value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Reprogram all three registers with the pipeline empty.
   task automatic load_config(input logic signed [31:0] min_value, input logic [31:0] scale,
                              input logic [2:0] map_sel);
      drain_pixels();
      write_csr(cgp_pkg::CSR_MIN_VALUE, min_value);
      write_csr(cgp_pkg::CSR_INV_RANGE_SCALE, scale);
      write_csr(cgp_pkg::CSR_COLORMAP_SELECT, {29'h0, map_sel});
   endtask

   // -------------------------------------------------------------------------
   // Main sequence.
   // -------------------------------------------------------------------------
   initial begin
      int unsigned      burst_left;
      int unsigned      shape;
      longint unsigned  span;
      longint unsigned  quotient;
      longint           offset;
      bit signed [31:0] min_pick;
      bit [31:0]        scale_pick;
      bit [2:0]         sel_pick;
      bit signed [31:0] sample_pick;
      bit               invalid_pick;

      pixel_board = new();
      repeat (RESET_CYCLES)
         @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset registers: minimum 0, range 1.0, jet. Hit the gradient ends,
      // saturation both ways, the exact top of the range and invalid samples.
      send_request(32'sd0, 1'b0);
      send_request(32'sh8000_0000, 1'b0);
      send_request(32'sh7FFF_FFFF, 1'b0);
      send_request(32'sd65536, 1'b0);
      send_request(32'sd32768, 1'b0);
      send_request(32'sd1, 1'b0);
      send_request(32'sd65535, 1'b0);
      send_request(32'sd10923, 1'b0);
      send_request(32'sh7FFF_FFFF, 1'b1);
      send_request(32'sh8000_0000, 1'b1);
      send_request(32'sd0, 1'b1);

      // Zero scale on hot: everything lands on the first stop.
      load_config(32'sh8000_0000, 32'h0, cgp_pkg::MAP_HOT);
      send_request(32'sh7FFF_FFFF, 1'b0);
      send_request(32'sd0, 1'b0);

      // Largest scale on viridis, minimum at the top: nothing gets above zero.
      load_config(32'sh7FFF_FFFF, 32'hFFFF_FFFF, cgp_pkg::MAP_VIRIDIS);
      send_request(32'sh8000_0000, 1'b0);
      send_request(32'sh7FFF_FFFF, 1'b0);

      // Largest scale with the widest possible offset: saturates at 1.0.
      load_config(32'sh8000_0000, 32'hFFFF_FFFF, cgp_pkg::MAP_VIRIDIS);
      send_request(32'sh7FFF_FFFF, 1'b0);

      // Grayscale and the unused selectors; a write past the register list
      // must leave everything alone.
      load_config(32'sd0, 32'h0001_0000, cgp_pkg::MAP_GRAYSCALE);
      send_request(32'sd32768, 1'b0);
      load_config(32'sd0, 32'h0001_0000, MAP_SPARE_LOW);
      write_csr(CSR_UNUSED_INDEX, 32'hFFFF_FFFF);
      send_request(32'sd49152, 1'b0);
      load_config(32'sd0, 32'h0001_0000, MAP_SPARE_TOP);
      send_request(32'sd16384, 1'b0);

      // Hot around its interior stops.
      load_config(32'sd0, 32'h0001_0000, cgp_pkg::MAP_HOT);
      send_request(32'sd21845, 1'b0);
      send_request(32'sd43691, 1'b0);

      // Random phases: each picks a minimum and a range, programs the scale
      // that matches it, then sends samples mostly spread across the range.
      burst_left = 0;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0:       span = 64'hFFFF_FFFF;
            1:       span = 1;
            default: span = {32'h0, $urandom} >> $urandom_range(0, 31);
         endcase
         if (span == 0)
            span = 1;
         quotient   = 64'h1_0000_0000 / span;
         scale_pick = (quotient > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quotient[31:0];

         case (phase)
            0:       min_pick = 32'sh8000_0000;
            3:       min_pick = 32'sh7FFF_FFFF;
            default: min_pick = $urandom;
         endcase
         sel_pick = (phase < 8) ? 3'(phase) : 3'($urandom_range(0, 7));
         load_config(min_pick, scale_pick, sel_pick);

         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            invalid_pick = ($urandom_range(0, 15) == 0);
            shape        = $urandom_range(0, 9);
            case (shape)
               1:       offset = -longint'($urandom_range(1, 4096));
               2:       offset = longint'(span) + longint'($urandom_range(0, 4096));
               default: offset = longint'(({32'h0, $urandom} * span) >> 32);
            endcase
            sample_pick = 32'(longint'(min_pick) + offset);
            // Mix in raw noise so every sample bit toggles.
            if (shape == 0)
               sample_pick = $urandom;
            send_request(sample_pick, invalid_pick);

            // Advance the burst; at its end leave a gap (sometimes none).
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               idle_request(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
            end else begin
               burst_left--;
            end
         end
      end

      drain_pixels();
      repeat (DRAIN_CYCLES)
         @(posedge clock);

      if (pixel_board.mismatch_count == 0 && pixel_board.pending() == 0) begin
         $display("PASS colormap_gradient_pixel");
      end else begin
         $display("FAIL colormap_gradient_pixel");
      end
      $finish;
   end

endmodule
